// ===== design/svpd_pkg.sv =====
//------------------------------------------------------------------------------
// svpd_pkg
// Shared widths, register indexes, reset values and arithmetic helpers for
// the space vector PWM duty core.
//------------------------------------------------------------------------------
`default_nettype none

package svpd_pkg;

	// field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned DUTY_W   = 16;
	localparam int unsigned PERIOD_W = 14;
	localparam int unsigned SQRT3_W  = 16;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SQRT3_PERIOD = 1'd1;

	localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST   = 14'd4000;
	localparam logic [SQRT3_W-1:0]  SQRT3_PERIOD_RST = 16'd13856;

	// datapath widths: wide words hold products, sums and differences,
	// narrow terms hold the scaled-down quotients and the duty sums
	localparam int unsigned WIDE_W = 34;
	localparam int unsigned TERM_W = 20;

	// truncating shifts: halving, lead difference, follower terms
	localparam int unsigned SH_HALF   = 1;
	localparam int unsigned SH_LEAD   = 18;
	localparam int unsigned SH_FOLLOW = 17;

	localparam logic signed [TERM_W-1:0] DUTY_MAX = 20'sd65535;

	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [TERM_W-1:0] term_t;

	// which difference leads the phase A duty
	typedef enum logic [2:0] {
		LEAD_YZ = 3'b001,
		LEAD_XZ = 3'b010,
		LEAD_YX = 3'b100
	} lead_t;

	// signed shift right that rounds toward zero, like C division
	function automatic wide_t div_pow2_trunc(input wide_t v, input int unsigned k);
		wide_t bias;
		bias = v[WIDE_W-1] ? ((wide_t'(1) <<< k) - wide_t'(1)) : '0;
		return (v + bias) >>> k;
	endfunction

	// clamp at zero, saturate at full scale
	function automatic logic [DUTY_W-1:0] clamp_duty(input term_t v);
		logic [DUTY_W-1:0] r;
		if (v[TERM_W-1]) begin
			r = '0;
		end else if (v > DUTY_MAX) begin
			r = '1;
		end else begin
			r = v[DUTY_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/svpd_in_if.sv =====
//------------------------------------------------------------------------------
// svpd_in_if
// Voltage vector channel: valid/ready handshake with alpha and beta.
//------------------------------------------------------------------------------
`default_nettype none

interface svpd_in_if
	import svpd_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] alpha;
	logic signed [SAMPLE_W-1:0] beta;

	modport source (output valid, output alpha, output beta, input ready);
	modport sink   (input valid, input alpha, input beta, output ready);
endinterface

`default_nettype wire

// ===== design/svpd_out_if.sv =====
//------------------------------------------------------------------------------
// svpd_out_if
// Duty channel: valid/ready handshake with three phase compare counts.
//------------------------------------------------------------------------------
`default_nettype none

interface svpd_out_if
	import svpd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_a;
	logic [DUTY_W-1:0] duty_b;
	logic [DUTY_W-1:0] duty_c;

	modport source (output valid, output duty_a, output duty_b, output duty_c, input ready);
	modport sink   (input valid, input duty_a, input duty_b, input duty_c, output ready);
endinterface

`default_nettype wire

// ===== design/space_vector_pwm_duty_core.sv =====
//------------------------------------------------------------------------------
// space_vector_pwm_duty_core
// Space vector modulation of one alpha/beta voltage vector into three phase
// compare counts, as a five-register pipeline.
//
//   channel  dir  handshake      payload
//   vec      in   valid/ready    alpha, beta (signed 16)
//   duty     out  valid/ready    duty_a, duty_b, duty_c (unsigned 16)
//   cfg      in   cfg_we only    cfg_index, cfg_wdata
//
// One vector per cycle while the duty channel is not stalled; each result passes all five registers in order.
// Stages: input register, the two multipliers, x/y/z, sector terms, duties.
// Each stage loads when it is empty or the next one moves, so bubbles close
// up and a stall at duty only backs up once the pipeline is full.
// arst_n clears all valid flags and loads the register reset values.
//------------------------------------------------------------------------------
`default_nettype none

module space_vector_pwm_duty_core
	import svpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	svpd_in_if.sink                    vec,
	svpd_out_if.source                 duty
);

	// configuration registers
	logic [PERIOD_W-1:0] pwm_period_q;
	logic [SQRT3_W-1:0]  sqrt3_period_q;

	// pipeline state
	logic                       v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic                       en_s1, en_s2, en_s3, en_s4, en_out;
	logic signed [SAMPLE_W-1:0] alpha_s1, beta_s1;
	wide_t                      ualpha_s2, ubeta_s2;
	wide_t                      x_s3, y_s3, z_s3;
	term_t                      lead_s4, off_b_s4, off_c_s4;
	logic [DUTY_W-1:0]          duty_a_q, duty_b_q, duty_c_q;

	// combinational stage logic
	wide_t ualpha_n, ubeta_n, beta_prod, sum_n, diff_n;
	wide_t lead_diff;
	term_t tx, ty, tz, quarter, ta, tb, tc;
	lead_t lead_sel;
	logic  y_neg, z_neg, x_le0;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q   <= PWM_PERIOD_RST;
			sqrt3_period_q <= SQRT3_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PWM_PERIOD:   pwm_period_q   <= cfg_wdata[PERIOD_W-1:0];
				CFG_SQRT3_PERIOD: sqrt3_period_q <= cfg_wdata[SQRT3_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables, a stage loads when empty or draining
	assign en_out    = !out_v_q || duty.ready;
	assign en_s4     = !v_s4 || en_out;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign vec.ready = en_s1;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1    <= vec.valid;
			if (en_s2)  v_s2    <= v_s1;
			if (en_s3)  v_s3    <= v_s2;
			if (en_s4)  v_s4    <= v_s3;
			if (en_out) out_v_q <= v_s4;
		end
	end

	// stage 2: alpha and beta scaling
	always_comb begin
		ualpha_n  = alpha_s1 * $signed({1'b0, sqrt3_period_q});
		beta_prod = beta_s1 * $signed({1'b0, pwm_period_q});
		ubeta_n   = -(beta_prod <<< 2);
	end

	// stage 3: auxiliary values
	always_comb begin
		sum_n  = div_pow2_trunc(ubeta_s2 + ualpha_s2, SH_HALF);
		diff_n = div_pow2_trunc(ubeta_s2 - ualpha_s2, SH_HALF);
	end

	// stage 4: sector pick, lead difference and follower offsets
	always_comb begin
		y_neg = y_s3[WIDE_W-1];
		z_neg = z_s3[WIDE_W-1];
		x_le0 = x_s3[WIDE_W-1] || (x_s3 == '0);
		if (y_neg == z_neg) begin
			lead_sel = LEAD_YZ;
		end else if (y_neg ? x_le0 : !x_le0) begin
			lead_sel = LEAD_XZ;
		end else begin
			lead_sel = LEAD_YX;
		end
		tx = term_t'(div_pow2_trunc(x_s3, SH_FOLLOW));
		ty = term_t'(div_pow2_trunc(y_s3, SH_FOLLOW));
		tz = term_t'(div_pow2_trunc(z_s3, SH_FOLLOW));
	end

	always_comb begin
		case (lead_sel)
			LEAD_YZ: lead_diff = y_s3 - z_s3;
			LEAD_XZ: lead_diff = x_s3 - z_s3;
			LEAD_YX: lead_diff = y_s3 - x_s3;
			default: lead_diff = y_s3 - z_s3;
		endcase
	end

	// stage 5: duty sums around the quarter period
	always_comb begin
		quarter = term_t'(pwm_period_q >> 2);
		ta      = quarter + lead_s4;
		tb      = ta + off_b_s4;
		tc      = ta + off_c_s4;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en_s1 && vec.valid) begin
			alpha_s1 <= vec.alpha;
			beta_s1  <= vec.beta;
		end
		if (en_s2 && v_s1) begin
			ualpha_s2 <= ualpha_n;
			ubeta_s2  <= ubeta_n;
		end
		if (en_s3 && v_s2) begin
			x_s3 <= ubeta_s2;
			y_s3 <= sum_n;
			z_s3 <= diff_n;
		end
		if (en_s4 && v_s3) begin
			lead_s4 <= term_t'(div_pow2_trunc(lead_diff, SH_LEAD));
			case (lead_sel)
				LEAD_YZ: begin
					off_b_s4 <= tz;
					off_c_s4 <= -ty;
				end
				LEAD_XZ: begin
					off_b_s4 <= tz;
					off_c_s4 <= tz - tx;
				end
				LEAD_YX: begin
					off_b_s4 <= tx - ty;
					off_c_s4 <= -ty;
				end
				default: begin
					off_b_s4 <= tz;
					off_c_s4 <= -ty;
				end
			endcase
		end
		if (en_out && v_s4) begin
			duty_a_q <= clamp_duty(ta);
			duty_b_q <= clamp_duty(tb);
			duty_c_q <= clamp_duty(tc);
		end
	end

	// result channel
	assign duty.valid  = out_v_q;
	assign duty.duty_a = duty_a_q;
	assign duty.duty_b = duty_b_q;
	assign duty.duty_c = duty_c_q;

endmodule

`default_nettype wire

// ===== design/svpd_checker.sv =====
//------------------------------------------------------------------------------
// svpd_checker
// Port-level checks for the space vector PWM duty core, bound to the top.
//------------------------------------------------------------------------------
`default_nettype none

module svpd_checker
	import svpd_pkg::*;
(
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       vec_valid,
	input wire logic                       vec_ready,
	input wire logic signed [SAMPLE_W-1:0] vec_alpha,
	input wire logic signed [SAMPLE_W-1:0] vec_beta,
	input wire logic                       duty_valid,
	input wire logic                       duty_ready,
	input wire logic [DUTY_W-1:0]          duty_a,
	input wire logic [DUTY_W-1:0]          duty_b,
	input wire logic [DUTY_W-1:0]          duty_c
);

	logic       vec_take;
	logic       clear_run;
	logic [4:0] take_hist_q;
	logic [3:0] ready_hist_q;
	logic [4:0] rstn_hist_q;

	assign vec_take = vec_valid && vec_ready;

	// short histories of take, output ready and reset, newest in bit 0
	always_ff @(posedge clk) begin
		take_hist_q  <= {take_hist_q[3:0], vec_take};
		ready_hist_q <= {ready_hist_q[2:0], duty_ready};
		rstn_hist_q  <= {rstn_hist_q[3:0], arst_n};
	end

	// item taken at the oldest take history sample, output drained and no reset since
	assign clear_run = take_hist_q[4] && (&ready_hist_q) && (&rstn_hist_q);

	// no result while reset is held
	a_no_valid_in_reset: assert property (@(posedge clk)
		!arst_n |-> !duty_valid)
		else $error("duty valid during reset");

	// a stalled result stays and holds its value
	a_duty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		duty_valid && !duty_ready |=>
			duty_valid && $stable(duty_a) && $stable(duty_b) && $stable(duty_c))
		else $error("stalled duty item changed");

	// with the output draining, a taken item reaches the duty register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		clear_run |-> duty_valid)
		else $error("duty item missing after pipeline latency");

	// a zero vector puts all three phases at the quarter period
	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		clear_run && $past(vec_alpha == '0, 5) && $past(vec_beta == '0, 5) |->
			duty_a == duty_b && duty_b == duty_c)
		else $error("zero vector gave unequal duties");

endmodule

bind space_vector_pwm_duty_core svpd_checker u_svpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.vec_valid  (vec.valid),
	.vec_ready  (vec.ready),
	.vec_alpha  (vec.alpha),
	.vec_beta   (vec.beta),
	.duty_valid (duty.valid),
	.duty_ready (duty.ready),
	.duty_a     (duty.duty_a),
	.duty_b     (duty.duty_b),
	.duty_c     (duty.duty_c)
);

`default_nettype wire
